// ----- sv/socks5_pkg.sv -----
// Shared types and constants for the SOCKS5 request header parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package socks5_pkg;

  localparam logic [7:0] SOCKS_VERSION  = 8'h05;
  localparam logic [7:0] RSV_VALUE      = 8'h00;
  localparam logic [7:0] ATYP_IPV4      = 8'h01;
  localparam logic [7:0] ATYP_IPV6      = 8'h04;
  localparam logic [7:0] ATYP_NAME      = 8'h03;
  localparam logic [7:0] CMD_FIRST      = 8'h01;
  localparam logic [7:0] CMD_LAST       = 8'h03;
  localparam logic [7:0] REP_FAIL_LAST  = 8'h08;
  localparam logic [7:0] IPV4_LEN       = 8'd4;
  localparam logic [7:0] IPV6_LEN       = 8'd16;

  localparam logic [1:0] HDR_LAST_IDX   = 2'd3;

  localparam logic MODE_REQUEST = 1'b0;
  localparam logic KIND_ADDR    = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_VER   = 3'd1;
  localparam logic [2:0] ST_BAD_RSV   = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_BAD_CMD   = 3'd4;
  localparam logic [2:0] ST_REP_FAIL  = 3'd5;
  localparam logic [2:0] ST_REP_UNK   = 3'd6;

  localparam logic [1:0] AK_IPV4 = 2'd0;
  localparam logic [1:0] AK_IPV6 = 2'd1;
  localparam logic [1:0] AK_NAME = 2'd2;

  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_NAMELEN = 5'b00010,
    PH_BODY    = 5'b00100,
    PH_PORTHI  = 5'b01000,
    PH_PORTLO  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] addr_byte;
    logic [7:0] addr_index;
    logic [2:0] status;
    logic [7:0] code;
    logic [1:0] addr_kind;
    logic [7:0] addr_length;
    logic [15:0] dest_port;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/socks5_parse_fsm.sv -----
// Message state machine: holds header/body/port state; forms address and end results.
// Depends on socks5_pkg.
`timescale 1ns / 1ps
`default_nettype none
module socks5_parse_fsm
  import socks5_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire logic       parse_mode,
  output logic            res_valid,
  output result_t         res
);

  phase_t     phase_r, phase_nxt;
  logic [1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0] version_r, version_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] rsv_r, rsv_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] body_len_r, body_len_nxt;
  logic [7:0] body_cnt_r, body_cnt_nxt;
  logic [7:0] port_hi_r, port_hi_nxt;

  logic [7:0] body_cnt_inc;
  logic [2:0] end_status;
  logic [2:0] hdr_status;

  assign body_cnt_inc = body_cnt_r + 8'd1;

  always_comb begin
    if (parse_mode == MODE_REQUEST) begin
      end_status = (code_r >= CMD_FIRST && code_r <= CMD_LAST) ? ST_OK : ST_BAD_CMD;
    end else if (code_r == 8'd0) begin
      end_status = ST_OK;
    end else if (code_r <= REP_FAIL_LAST) begin
      end_status = ST_REP_FAIL;
    end else begin
      end_status = ST_REP_UNK;
    end
  end

  // version, then reserved, then type; first failure wins
  always_comb begin
    if (version_r != SOCKS_VERSION) begin
      hdr_status = ST_BAD_VER;
    end else if (rsv_r != RSV_VALUE) begin
      hdr_status = ST_BAD_RSV;
    end else if (rx_byte != ATYP_IPV4 && rx_byte != ATYP_IPV6 && rx_byte != ATYP_NAME) begin
      hdr_status = ST_BAD_TYPE;
    end else begin
      hdr_status = ST_OK;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    version_nxt  = version_r;
    code_nxt     = code_r;
    rsv_nxt      = rsv_r;
    kind_nxt     = kind_r;
    body_len_nxt = body_len_r;
    body_cnt_nxt = body_cnt_r;
    port_hi_nxt  = port_hi_r;
    res_valid    = 1'b0;
    res          = '0;

    unique case (phase_r)
      PH_NAMELEN: begin
        body_len_nxt = rx_byte;
        body_cnt_nxt = 8'd0;
        phase_nxt    = (rx_byte != 8'd0) ? PH_BODY : PH_PORTHI;
      end
      PH_BODY: begin
        res_valid        = 1'b1;
        res.result_kind  = KIND_ADDR;
        res.addr_byte    = rx_byte;
        res.addr_index   = body_cnt_r;
        body_cnt_nxt     = body_cnt_inc;
        if (body_cnt_inc == body_len_r) begin
          phase_nxt = PH_PORTHI;
        end
      end
      PH_PORTHI: begin
        port_hi_nxt = rx_byte;
        phase_nxt   = PH_PORTLO;
      end
      PH_PORTLO: begin
        res_valid       = 1'b1;
        res.result_kind = KIND_END;
        res.status      = end_status;
        res.code        = code_r;
        res.addr_kind   = kind_r;
        res.addr_length = body_len_r;
        res.dest_port   = {port_hi_r, rx_byte};
        phase_nxt       = PH_HEADER;
        hdr_cnt_nxt     = 2'd0;
      end
      default: begin
        // header octets; unreachable phase codes land here too
        phase_nxt = PH_HEADER;
        case (hdr_cnt_r)
          2'd0:    version_nxt = rx_byte;
          2'd1:    code_nxt    = rx_byte;
          2'd2:    rsv_nxt     = rx_byte;
          default: ;
        endcase
        if (hdr_cnt_r != HDR_LAST_IDX) begin
          hdr_cnt_nxt = hdr_cnt_r + 2'd1;
        end else begin
          hdr_cnt_nxt = 2'd0;
          if (hdr_status != ST_OK) begin
            res_valid       = 1'b1;
            res.result_kind = KIND_END;
            res.status      = hdr_status;
            res.code        = code_r;
          end else begin
            body_cnt_nxt = 8'd0;
            if (rx_byte == ATYP_IPV4) begin
              kind_nxt     = AK_IPV4;
              body_len_nxt = IPV4_LEN;
              phase_nxt    = PH_BODY;
            end else if (rx_byte == ATYP_IPV6) begin
              kind_nxt     = AK_IPV6;
              body_len_nxt = IPV6_LEN;
              phase_nxt    = PH_BODY;
            end else begin
              kind_nxt     = AK_NAME;
              body_len_nxt = 8'd0;
              phase_nxt    = PH_NAMELEN;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_cnt_r  <= 2'd0;
      version_r  <= 8'd0;
      code_r     <= 8'd0;
      rsv_r      <= 8'd0;
      kind_r     <= AK_IPV4;
      body_len_r <= 8'd0;
      body_cnt_r <= 8'd0;
      port_hi_r  <= 8'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      version_r  <= version_nxt;
      code_r     <= code_nxt;
      rsv_r      <= rsv_nxt;
      kind_r     <= kind_nxt;
      body_len_r <= body_len_nxt;
      body_cnt_r <= body_cnt_nxt;
      port_hi_r  <= port_hi_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/socks5_out_reg.sv -----
// Result register: holds one formed result until the downstream side takes it.
// Depends on socks5_pkg.
`timescale 1ns / 1ps
`default_nettype none
module socks5_out_reg
  import socks5_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res_in,
  input  wire logic    take,
  output logic         valid,
  output result_t      res_out
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule
`default_nettype wire

// ----- sv/socks5_request_header_parser.sv -----
// Top level of the SOCKS5 request/reply header parser: mode register, FSM, result register.
// Depends on socks5_pkg, socks5_parse_fsm, socks5_out_reg.
//
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------------------
//  in      | in_tvalid/in_tready/in_tdata   | rx_byte, one octet per request
//  out     | out_tvalid/out_tready/out_tdata| address octet or end-of-message result
//          | out_tuser                      | result_kind
//  cfg     | cfg_wr_en/cfg_wr_data          | parse_mode
//
// One octet per cycle unless stalled; each result shows in the cycle after its octet.
// in_tready drops only while a result waits and out_tready is low.
// Synchronous active-low reset returns to the header phase in request mode.
`timescale 1ns / 1ps
`default_nettype none
module socks5_request_header_parser
  import socks5_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [0:0]             cfg_wr_data,  // [0] parse_mode
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,     // [7:0] rx_byte
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [7:0] addr_byte, [15:8] addr_index, [18:16] status, [26:19] code,
  // [28:27] addr_kind, [36:29] addr_length, [52:37] dest_port, [55:53] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser     // [0] result_kind
);

  logic    mode_r;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t res_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_REQUEST;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data[0];
    end
  end

  assign in_tready = !out_tvalid || out_tready;
  assign step      = in_tvalid && in_tready;

  socks5_parse_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .rx_byte    (in_tdata),
    .parse_mode (mode_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  socks5_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (step && res_valid),
    .res_in  (res),
    .take    (out_tready),
    .valid   (out_tvalid),
    .res_out (res_q)
  );

  assign out_tuser = res_q.result_kind;
  assign out_tdata = {3'b000, res_q.dest_port, res_q.addr_length, res_q.addr_kind,
                      res_q.code, res_q.status, res_q.addr_index, res_q.addr_byte};

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for socks5_request_header_parser: directed and random octet streams
// with random idling on both channels, checked against an in-bench parser model.
// Depends on socks5_pkg and the socks5_request_header_parser RTL.
`timescale 1ns / 1ps
module tb_top;
  import socks5_pkg::*;

  localparam logic MODE_REPLY  = ~MODE_REQUEST;
  localparam int   STUCK_LIMIT = 1000;
  localparam int   PHASE_OCTETS = 28;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [0:0]             cfg_wr_data = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  socks5_request_header_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] queued_octets[$];
  result_t    due_results[$];

  // parser model state
  logic       mode_model = MODE_REQUEST;
  phase_t     p_phase = PH_HEADER;
  logic [1:0] p_hdr_cnt = '0;
  logic [7:0] p_version = '0;
  logic [7:0] p_code = '0;
  logic [7:0] p_reserved = '0;
  logic [1:0] p_kind = '0;
  logic [7:0] p_body_len = '0;
  logic [7:0] p_body_cnt = '0;
  logic [7:0] p_port_hi = '0;

  bit hold_off = 0;
  bit no_idle = 0;
  int in_gap = 0;
  int out_stall = 0;
  int stuck_cycles = 0;
  int mismatches = 0;
  int n_octets = 0;
  int n_addr = 0;
  int n_end = 0;
  int n_hdr_err = 0;

  task automatic parse_octet(input logic [7:0] b);
    result_t r;
    r = '0;
    case (p_phase)
      PH_NAMELEN: begin
        p_body_len = b;
        p_body_cnt = '0;
        p_phase = (b != 8'd0) ? PH_BODY : PH_PORTHI;
      end
      PH_BODY: begin
        r.result_kind = KIND_ADDR;
        r.addr_byte = b;
        r.addr_index = p_body_cnt;
        due_results.push_back(r);
        p_body_cnt = p_body_cnt + 8'd1;
        if (p_body_cnt == p_body_len) p_phase = PH_PORTHI;
      end
      PH_PORTHI: begin
        p_port_hi = b;
        p_phase = PH_PORTLO;
      end
      PH_PORTLO: begin
        r.result_kind = KIND_END;
        // mode is taken at the end of the message, not at its start
        if (mode_model == MODE_REQUEST)
          r.status = (p_code >= CMD_FIRST && p_code <= CMD_LAST) ? ST_OK : ST_BAD_CMD;
        else if (p_code == 8'd0)
          r.status = ST_OK;
        else if (p_code <= REP_FAIL_LAST)
          r.status = ST_REP_FAIL;
        else
          r.status = ST_REP_UNK;
        r.code = p_code;
        r.addr_kind = p_kind;
        r.addr_length = p_body_len;
        r.dest_port = {p_port_hi, b};
        due_results.push_back(r);
        p_phase = PH_HEADER;
        p_hdr_cnt = '0;
      end
      default: begin
        p_phase = PH_HEADER;
        case (p_hdr_cnt)
          2'd0: p_version = b;
          2'd1: p_code = b;
          2'd2: p_reserved = b;
          default: ;
        endcase
        if (p_hdr_cnt != HDR_LAST_IDX) begin
          p_hdr_cnt = p_hdr_cnt + 2'd1;
        end else begin
          p_hdr_cnt = '0;
          r.status = ST_OK;
          if (p_version != SOCKS_VERSION) r.status = ST_BAD_VER;
          else if (p_reserved != RSV_VALUE) r.status = ST_BAD_RSV;
          else if (b != ATYP_IPV4 && b != ATYP_IPV6 && b != ATYP_NAME) r.status = ST_BAD_TYPE;
          if (r.status != ST_OK) begin
            // error result: only status and code carry information
            r.result_kind = KIND_END;
            r.code = p_code;
            due_results.push_back(r);
            n_hdr_err++;
          end else begin
            p_body_cnt = '0;
            if (b == ATYP_IPV4) begin
              p_kind = AK_IPV4;
              p_body_len = IPV4_LEN;
              p_phase = PH_BODY;
            end else if (b == ATYP_IPV6) begin
              p_kind = AK_IPV6;
              p_body_len = IPV6_LEN;
              p_phase = PH_BODY;
            end else begin
              p_kind = AK_NAME;
              p_body_len = '0;
              p_phase = PH_NAMELEN;
            end
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
  endtask

  task automatic check_result(input logic kind, input logic [OUT_TDATA_W-1:0] d);
    result_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result with nothing due, kind", kind, 0);
      return;
    end
    want = due_results.pop_front();
    if (kind != want.result_kind) report_mismatch("result_kind", kind, want.result_kind);
    if (d[7:0] != want.addr_byte) report_mismatch("addr_byte", d[7:0], want.addr_byte);
    if (d[15:8] != want.addr_index) report_mismatch("addr_index", d[15:8], want.addr_index);
    if (d[18:16] != want.status) report_mismatch("status", d[18:16], want.status);
    if (d[26:19] != want.code) report_mismatch("code", d[26:19], want.code);
    if (d[28:27] != want.addr_kind) report_mismatch("addr_kind", d[28:27], want.addr_kind);
    if (d[36:29] != want.addr_length)
      report_mismatch("addr_length", d[36:29], want.addr_length);
    if (d[52:37] != want.dest_port) report_mismatch("dest_port", d[52:37], want.dest_port);
    if (want.result_kind == KIND_ADDR) n_addr++;
    else n_end++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (hold_off || queued_octets.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 5);
        in_tvalid <= 1'b0;
      end else begin
        in_tdata <= queued_octets.pop_front();
        in_tvalid <= 1'b1;
      end
    end
  end

  // result backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        parse_octet(in_tdata);
        n_octets++;
      end
      if (out_tvalid && out_tready) check_result(out_tuser, out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stuck_cycles = 0;
      end else if (in_tvalid || queued_octets.size() != 0 || due_results.size() != 0) begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("timeout after %0d cycles without progress", stuck_cycles);
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  task automatic queue_message(input logic [7:0] ver, input logic [7:0] code,
                               input logic [7:0] rsv, input logic [7:0] atyp,
                               input logic [7:0] name_len, input logic [15:0] port);
    int body;
    queued_octets.push_back(ver);
    queued_octets.push_back(code);
    queued_octets.push_back(rsv);
    queued_octets.push_back(atyp);
    if (ver != SOCKS_VERSION || rsv != RSV_VALUE) return;
    if (atyp == ATYP_IPV4) body = IPV4_LEN;
    else if (atyp == ATYP_IPV6) body = IPV6_LEN;
    else if (atyp == ATYP_NAME) begin
      body = name_len;
      queued_octets.push_back(name_len);
    end else return;
    repeat (body) queued_octets.push_back(8'($urandom_range(0, 255)));
    queued_octets.push_back(port[15:8]);
    queued_octets.push_back(port[7:0]);
  endtask

  task automatic queue_random_messages(input int budget);
    int start;
    logic [7:0] ver, code, rsv, atyp, nlen;
    start = queued_octets.size();
    while (queued_octets.size() - start < budget) begin
      ver = SOCKS_VERSION;
      rsv = RSV_VALUE;
      case ($urandom_range(0, 2))
        0: atyp = ATYP_IPV4;
        1: atyp = ATYP_IPV6;
        default: atyp = ATYP_NAME;
      endcase
      code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 10));
      nlen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40))
                                         : 8'($urandom_range(0, 6));
      // about one in five is a broken header
      case ($urandom_range(0, 14))
        0: begin
          ver = 8'($urandom_range(0, 255));
          if (ver == SOCKS_VERSION) ver = ~ver;
          rsv = 8'($urandom_range(0, 255));
        end
        1: rsv = 8'($urandom_range(1, 255));
        2: begin
          atyp = 8'($urandom_range(0, 255));
          if (atyp == ATYP_IPV4 || atyp == ATYP_IPV6 || atyp == ATYP_NAME) atyp[7] = 1'b1;
        end
        default: ;
      endcase
      queue_message(ver, code, rsv, atyp, nlen, 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic settle();
    @(negedge clk);
    while (queued_octets.size() != 0 || in_tvalid || due_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_parse_mode(input logic m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_model = m;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_parse_mode(MODE_REQUEST);

    // header errors in check order, then an empty name with extreme port
    queue_message(8'h00, 8'h01, RSV_VALUE, ATYP_IPV4, 8'd0, 16'h0000);
    queue_message(SOCKS_VERSION, 8'h02, 8'hFF, ATYP_IPV4, 8'd0, 16'h0000);
    queue_message(SOCKS_VERSION, 8'h03, RSV_VALUE, 8'hFF, 8'd0, 16'h0000);
    queue_message(SOCKS_VERSION, CMD_FIRST, RSV_VALUE, ATYP_NAME, 8'd0, 16'hFFFF);
    // mode flips between the two port octets
    queued_octets.push_back(SOCKS_VERSION);
    queued_octets.push_back(8'h00);
    queued_octets.push_back(RSV_VALUE);
    queued_octets.push_back(ATYP_IPV4);
    queued_octets.push_back(8'h00);
    queued_octets.push_back(8'hFF);
    queued_octets.push_back(8'h80);
    queued_octets.push_back(8'h7F);
    queued_octets.push_back(8'h12);
    settle();
    set_parse_mode(MODE_REPLY);
    queued_octets.push_back(8'h34);
    settle();

    set_parse_mode(MODE_REQUEST);
    queue_random_messages(PHASE_OCTETS);
    // sender holds until every result is out
    @(negedge clk);
    while (queued_octets.size() > PHASE_OCTETS / 2) @(negedge clk);
    hold_off = 1;
    while (in_tvalid || due_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    hold_off = 0;
    settle();

    set_parse_mode(MODE_REPLY);
    queue_message(SOCKS_VERSION, REP_FAIL_LAST, RSV_VALUE, ATYP_NAME, 8'd255, 16'h8001);
    queue_random_messages(PHASE_OCTETS);
    settle();

    set_parse_mode(MODE_REQUEST);
    queue_random_messages(PHASE_OCTETS);
    settle();

    set_parse_mode(MODE_REPLY);
    queue_random_messages(PHASE_OCTETS);
    settle();

    no_idle = 1;
    set_parse_mode(MODE_REQUEST);
    queue_random_messages(PHASE_OCTETS);
    settle();

    $display("run: %0d octets in, %0d address octets and %0d message results compared",
             n_octets, n_addr, n_end);
    $display("run: %0d header errors, request and reply modes, names up to 255 octets",
             n_hdr_err);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
